@@ src/mhpq_pkg.sv @@
// Shared types and constants of the max-heap priority queue core.
package mhpq_pkg;

   // Number of values the queue can hold, and the width of one value.
   localparam int CAPACITY    = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int OP_WIDTH    = 3;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

   // Operation codes carried by a request transaction.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_SEARCH  = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_READOUT = 3'd4
   } op_type;

   // Commands broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      CMD_HOLD   = 3'd0,
      CMD_CMP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_ROTATE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   // Control group from the sequencer to the chain.
   typedef struct packed {
      cmd_type                        cmd;
      logic signed [VALUE_WIDTH-1:0]  key;
   } ctrl_type;

   // What one cell shows to its neighbours.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           valid;
      logic                           gt;
      logic                           eq;
   } link_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CMP   = 5'b00010,
      S_APPLY = 5'b00100,
      S_READ  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

endpackage

@@ src/mhpq_req_if.sv @@
// Request channel: operation and operand, with valid/ready handshake.
interface mhpq_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [mhpq_pkg::OP_WIDTH-1:0]              operation;
   logic signed [mhpq_pkg::VALUE_WIDTH-1:0]    item_value;

   modport source (output valid, operation, item_value, input ready);
   modport sink   (input valid, operation, item_value, output ready);
endinterface

@@ src/mhpq_rsp_if.sv @@
// Response channel: status, readout value and occupancy, with valid/ready handshake.
interface mhpq_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       ok;
   logic                                       full_refused;
   logic signed [mhpq_pkg::VALUE_WIDTH-1:0]    out_value;
   logic                                       has_value;
   logic                                       last;
   logic [mhpq_pkg::COUNT_WIDTH-1:0]           entry_count;
   logic                                       empty_res;

   modport source (output valid, ok, full_refused, out_value, has_value, last,
                   entry_count, empty_res, input ready);
   modport sink   (input valid, ok, full_refused, out_value, has_value, last,
                   entry_count, empty_res, output ready);
endinterface

@@ src/mhpq_cell.sv @@
// One cell of the sorted chain: holds a value, its valid bit and compare flags.
module mhpq_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  mhpq_pkg::ctrl_type          ctrl,
   input  logic                        first,
   input  logic signed [mhpq_pkg::VALUE_WIDTH-1:0] head_value,
   input  mhpq_pkg::link_type          prev,
   input  mhpq_pkg::link_type          next,
   output mhpq_pkg::link_type          self
);

   logic signed [mhpq_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic                                    valid_ff, valid_in;
   logic                                    gt_ff, gt_in;
   logic                                    eq_ff, eq_in;

   // Next-state logic for the broadcast command.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      case (ctrl.cmd)
         mhpq_pkg::CMD_CMP: begin
            gt_in = valid_ff && (value_ff > ctrl.key);
            eq_in = valid_ff && (value_ff == ctrl.key);
         end
         mhpq_pkg::CMD_INSERT: begin
            // Larger values stay; the first smaller slot takes the key, the rest shift down.
            if (!gt_ff) begin
               if (first || prev.gt) begin
                  value_in = ctrl.key;
                  valid_in = 1'b1;
               end else begin
                  value_in = prev.value;
                  valid_in = prev.valid;
               end
            end
         end
         mhpq_pkg::CMD_REMOVE: begin
            // The matching cell and all after it pull from the next cell.
            if (!gt_ff) begin
               value_in = next.value;
               valid_in = next.valid;
            end
         end
         mhpq_pkg::CMD_ROTATE: begin
            // Rotate the occupied part by one: the last occupied cell takes the head.
            if (valid_ff) begin
               if (!next.valid) begin
                  value_in = head_value;
               end else begin
                  value_in = next.value;
               end
            end
         end
         mhpq_pkg::CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Cell registers; only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign self = '{value: value_ff, valid: valid_ff, gt: gt_ff, eq: eq_ff};

endmodule

@@ src/mhpq_chain.sv @@
// Row of cells kept in descending order, with match detection over all cells.
module mhpq_chain (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mhpq_pkg::ctrl_type                       ctrl,
   output logic                                     found,
   output logic signed [mhpq_pkg::VALUE_WIDTH-1:0]  head_value
);

   mhpq_pkg::link_type              links [mhpq_pkg::CAPACITY];
   logic [mhpq_pkg::CAPACITY-1:0]   eq_vec;

   // Cells, each wired to both neighbours; the ends see an empty cell.
   for (genvar i = 0; i < mhpq_pkg::CAPACITY; i++) begin : g_cell
      mhpq_pkg::link_type prev_link;
      mhpq_pkg::link_type next_link;

      if (i == 0) begin : g_first
         assign prev_link = '0;
      end else begin : g_mid_prev
         assign prev_link = links[i-1];
      end

      if (i == mhpq_pkg::CAPACITY - 1) begin : g_last
         assign next_link = '0;
      end else begin : g_mid_next
         assign next_link = links[i+1];
      end

      mhpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .first      (i == 0),
         .head_value (head_value),
         .prev       (prev_link),
         .next       (next_link),
         .self       (links[i])
      );

      assign eq_vec[i] = links[i].eq;
   end

   // Registered match flags reduce to one found bit.
   assign found      = |eq_vec;
   assign head_value = links[0].value;

endmodule

@@ src/max_heap_priority_queue_core.sv @@
// Top level of the max-heap priority queue core: sequencer, chain and response register.
//
// The queue keeps up to CAPACITY unique signed values in a chain of cells held in descending
// order, which gives the same observable behaviour as a binary max-heap. Insert, remove,
// search, clear and an unknown operation each present their single response once the request has
// passed through the compare state, in which every cell compares, and the apply state, which applies
// the shift, and the next request is taken in the cycle after that response transaction completes.
// A sorted readout of n values goes through the same two states and then the read state, which
// loads one value per cycle into the response register while the response side is ready; the chain
// rotates by one cell per value and is back in its original order after the last one. None of this
// depends on the capacity.
module max_heap_priority_queue_core (
   input  logic          clock,
   input  logic          reset,
   mhpq_req_if.sink      req_chan,
   mhpq_rsp_if.source    rsp_chan
);

   mhpq_pkg::state_type                        state_ff, state_in;
   logic [mhpq_pkg::OP_WIDTH-1:0]              op_ff, op_in;
   logic signed [mhpq_pkg::VALUE_WIDTH-1:0]    key_ff, key_in;
   logic [mhpq_pkg::COUNT_WIDTH-1:0]           count_ff, count_in;
   logic [mhpq_pkg::COUNT_WIDTH-1:0]           remain_ff, remain_in;

   logic                                       rsp_valid_ff, rsp_valid_in;
   logic                                       ok_ff, ok_in;
   logic                                       full_ff, full_in;
   logic signed [mhpq_pkg::VALUE_WIDTH-1:0]    value_ff, value_in;
   logic                                       has_ff, has_in;
   logic                                       last_ff, last_in;
   logic [mhpq_pkg::COUNT_WIDTH-1:0]           rcount_ff, rcount_in;
   logic                                       empty_ff, empty_in;

   mhpq_pkg::ctrl_type                         ctrl;
   logic                                       found;
   logic signed [mhpq_pkg::VALUE_WIDTH-1:0]    head_value;
   logic                                       rsp_free;

   mhpq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .found      (found),
      .head_value (head_value)
   );

   assign req_chan.ready = (state_ff == mhpq_pkg::S_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer: decides the chain command and builds each response.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      ctrl.cmd     = mhpq_pkg::CMD_HOLD;
      ctrl.key     = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ok_in        = ok_ff;
      full_in      = full_ff;
      value_in     = value_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      rcount_in    = rcount_ff;
      empty_in     = empty_ff;

      case (state_ff)
         mhpq_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.operation;
               key_in   = req_chan.item_value;
               state_in = mhpq_pkg::S_CMP;
            end
         end
         mhpq_pkg::S_CMP: begin
            ctrl.cmd = mhpq_pkg::CMD_CMP;
            state_in = mhpq_pkg::S_APPLY;
         end
         mhpq_pkg::S_APPLY: begin
            ok_in    = 1'b0;
            full_in  = 1'b0;
            value_in = '0;
            has_in   = 1'b0;
            last_in  = 1'b1;
            state_in = mhpq_pkg::S_RESP;
            case (op_ff)
               mhpq_pkg::OP_INSERT: begin
                  // A duplicate is refused before the full check.
                  if (!found) begin
                     if (count_ff == mhpq_pkg::FULL_COUNT) begin
                        full_in = 1'b1;
                     end else begin
                        ctrl.cmd = mhpq_pkg::CMD_INSERT;
                        count_in = count_ff + mhpq_pkg::COUNT_ONE;
                        ok_in    = 1'b1;
                     end
                  end
               end
               mhpq_pkg::OP_REMOVE: begin
                  if (found) begin
                     ctrl.cmd = mhpq_pkg::CMD_REMOVE;
                     count_in = count_ff - mhpq_pkg::COUNT_ONE;
                     ok_in    = 1'b1;
                  end
               end
               mhpq_pkg::OP_SEARCH: begin
                  ok_in = found;
               end
               mhpq_pkg::OP_CLEAR: begin
                  ctrl.cmd = mhpq_pkg::CMD_CLEAR;
                  count_in = '0;
                  ok_in    = 1'b1;
               end
               mhpq_pkg::OP_READOUT: begin
                  // An empty queue gives a single response with no value.
                  if (count_ff != '0) begin
                     remain_in = count_ff;
                     state_in  = mhpq_pkg::S_READ;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            rcount_in = count_in;
            empty_in  = (count_in == '0);
            if (state_in == mhpq_pkg::S_RESP) begin
               rsp_valid_in = 1'b1;
            end
         end
         mhpq_pkg::S_READ: begin
            // Emit the head and rotate the chain whenever the response register frees up.
            if (rsp_free) begin
               ctrl.cmd     = mhpq_pkg::CMD_ROTATE;
               rsp_valid_in = 1'b1;
               ok_in        = 1'b0;
               full_in      = 1'b0;
               value_in     = head_value;
               has_in       = 1'b1;
               last_in      = (remain_ff == mhpq_pkg::COUNT_ONE);
               rcount_in    = count_ff;
               empty_in     = 1'b0;
               remain_in    = remain_ff - mhpq_pkg::COUNT_ONE;
               if (remain_ff == mhpq_pkg::COUNT_ONE) begin
                  state_in = mhpq_pkg::S_RESP;
               end
            end
         end
         mhpq_pkg::S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = mhpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      ok_ff     <= ok_in;
      full_ff   <= full_in;
      value_ff  <= value_in;
      has_ff    <= has_in;
      last_ff   <= last_in;
      rcount_ff <= rcount_in;
      empty_ff  <= empty_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = ok_ff;
   assign rsp_chan.full_refused = full_ff;
   assign rsp_chan.out_value    = value_ff;
   assign rsp_chan.has_value    = has_ff;
   assign rsp_chan.last         = last_ff;
   assign rsp_chan.entry_count  = rcount_ff;
   assign rsp_chan.empty_res    = empty_ff;

endmodule

@@ test/max_heap_priority_queue_core_tb.sv @@
// Self-checking testbench for the max-heap priority queue core, with its own heap predictor.
module max_heap_priority_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int MAX_WAIT      = 16;
   localparam int SETTLE_CYCLES = 32;
   localparam int POOL_SIZE     = 48;

   // Operation codes the core does not implement; they must be answered and ignored.
   localparam logic [OP_WIDTH-1:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_UNKNOWN_HI = 3'd7;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type VALUE_MAX = ~VALUE_MIN;

   // One expected response transaction.
   typedef struct packed {
      logic                   ok;
      logic                   full_refused;
      value_type              out_value;
      logic                   has_value;
      logic                   last;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   empty_res;
   } heap_reply_type;

   logic clock = 1'b0;
   logic reset;

   mhpq_req_if req_bus ();
   mhpq_rsp_if rsp_bus ();

   max_heap_priority_queue_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state: a binary max-heap of signed values.
   value_type      heap_vals [CAPACITY];
   value_type      readout_vals [CAPACITY];
   int             heap_size = 0;
   heap_reply_type pending_replies [$];
   heap_reply_type front_reply;

   int error_count   = 0;
   int cycle_count   = 0;
   int next_req_gap  = 0;
   int rsp_stall     = 0;
   bit req_held      = 1'b0;
   bit req_quiet     = 1'b0;
   bit rsp_quiet     = 1'b0;

   always #5 clock = ~clock;

   // Idle cycles before the next transaction on either side; none during a quiet stretch.
   function automatic int draw_wait(bit quiet);
      if (quiet) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Linear search of the stored values; -1 when absent.
   function automatic int find_value(value_type v);
      for (int i = 0; i < heap_size; i++) begin
         if (heap_vals[i] == v) return i;
      end
      return -1;
   endfunction

   function automatic void swap_entries(int a, int b);
      value_type tmp;
      tmp          = heap_vals[a];
      heap_vals[a] = heap_vals[b];
      heap_vals[b] = tmp;
   endfunction

   function automatic int sift_up(int idx);
      int parent;
      while (idx > 0) begin
         parent = (idx - 1) / 2;
         if (heap_vals[idx] <= heap_vals[parent]) break;
         swap_entries(idx, parent);
         idx = parent;
      end
      return idx;
   endfunction

   function automatic void sift_down(int idx);
      int biggest;
      while (idx < heap_size) begin
         biggest = idx;
         if (2*idx + 1 < heap_size && heap_vals[2*idx + 1] > heap_vals[biggest])
            biggest = 2*idx + 1;
         if (2*idx + 2 < heap_size && heap_vals[2*idx + 2] > heap_vals[biggest])
            biggest = 2*idx + 2;
         if (biggest == idx) break;
         swap_entries(idx, biggest);
         idx = biggest;
      end
   endfunction

   function automatic void push_reply(logic ok, logic full, value_type v, logic has,
                                      logic last);
      heap_reply_type r;
      r.ok           = ok;
      r.full_refused = full;
      r.out_value    = v;
      r.has_value    = has;
      r.last         = last;
      r.entry_count  = COUNT_WIDTH'(heap_size);
      r.empty_res    = (heap_size == 0);
      pending_replies = {pending_replies, r};
   endfunction

   // Applies one accepted request to the heap and queues the responses it causes.
   function automatic void predict_heap_replies(logic [OP_WIDTH-1:0] op, value_type v);
      int   pos;
      int   remaining;
      int   top;
      logic ok;
      logic full;
      ok   = 1'b0;
      full = 1'b0;
      case (op)
         OP_INSERT: begin
            // A duplicate is refused before the capacity is looked at.
            if (find_value(v) < 0) begin
               if (heap_size >= CAPACITY) begin
                  full = 1'b1;
               end else begin
                  heap_vals[heap_size] = v;
                  heap_size++;
                  pos = sift_up(heap_size - 1);
                  ok  = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            // The last entry fills the hole and may have to move either way.
            pos = find_value(v);
            if (pos >= 0) begin
               heap_size--;
               heap_vals[pos] = heap_vals[heap_size];
               if (pos < heap_size) begin
                  pos = sift_up(pos);
                  sift_down(pos);
               end
               ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            ok = (find_value(v) >= 0);
         end
         OP_CLEAR: begin
            heap_size = 0;
            ok        = 1'b1;
         end
         OP_READOUT: begin
            // An empty heap still gives one response, without a value.
            if (heap_size == 0) begin
               push_reply(1'b0, 1'b0, '0, 1'b0, 1'b1);
               return;
            end
            // Largest first from a working copy; the heap itself is untouched.
            for (int i = 0; i < heap_size; i++) readout_vals[i] = heap_vals[i];
            remaining = heap_size;
            while (remaining > 0) begin
               top = 0;
               for (int j = 1; j < remaining; j++) begin
                  if (readout_vals[j] > readout_vals[top]) top = j;
               end
               push_reply(1'b0, 1'b0, readout_vals[top], 1'b1, remaining == 1);
               readout_vals[top] = readout_vals[remaining - 1];
               remaining--;
            end
            return;
         end
         default: ;
      endcase
      push_reply(ok, full, '0, 1'b0, 1'b1);
   endfunction

   function automatic void check_field(string name, logic signed [VALUE_WIDTH:0] want,
                                       logic signed [VALUE_WIDTH:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Sends one request transaction; valid stays high when the next one follows at once.
   task automatic send_item(input logic [OP_WIDTH-1:0] op, input value_type v);
      repeat (next_req_gap) @(posedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.item_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_heap_replies(op, v);
      next_req_gap = draw_wait(req_quiet);
      req_held     = (next_req_gap == 0);
      if (!req_held) req_bus.valid <= 1'b0;
   endtask

   // Holds the request side until every outstanding response has arrived.
   task automatic wait_for_drain();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
      next_req_gap = 0;
      @(posedge clock);
      while (pending_replies.size() > 0) @(posedge clock);
   endtask

   // Extremes of the operand, every operation and the duplicate, absent and empty cases in a short sequence.
   task automatic test_directed_ops();
      send_item(OP_READOUT, VALUE_MAX);
      send_item(OP_SEARCH, '0);
      send_item(OP_REMOVE, VALUE_MIN);
      send_item(OP_INSERT, VALUE_MIN);
      send_item(OP_INSERT, VALUE_MAX);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, -1);
      send_item(OP_INSERT, 1);
      send_item(OP_INSERT, VALUE_MAX);
      send_item(OP_SEARCH, VALUE_MIN);
      send_item(OP_SEARCH, 2);
      send_item(OP_READOUT, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_REMOVE, VALUE_MAX);
      for (int op = OP_UNKNOWN_LO; op <= OP_UNKNOWN_HI; op++) begin
         send_item(OP_WIDTH'(op), $urandom);
      end
      send_item(OP_READOUT, VALUE_MIN);
      send_item(OP_CLEAR, $urandom);
      send_item(OP_READOUT, $urandom);
      send_item(OP_SEARCH, 1);
   endtask

   // Fills the heap, probes both refusals, then removes from arbitrary positions.
   task automatic test_full_heap();
      value_type v;
      send_item(OP_CLEAR, $urandom);
      while (heap_size < CAPACITY) begin
         v = $urandom;
         if (find_value(v) < 0) send_item(OP_INSERT, v);
      end
      send_item(OP_INSERT, heap_vals[$urandom_range(0, CAPACITY - 1)]);
      do v = $urandom; while (find_value(v) >= 0);
      send_item(OP_INSERT, v);
      send_item(OP_SEARCH, heap_vals[$urandom_range(0, CAPACITY - 1)]);
      send_item(OP_READOUT, $urandom);
      repeat (8) send_item(OP_REMOVE, heap_vals[$urandom_range(0, heap_size - 1)]);
      send_item(OP_READOUT, $urandom);
      wait_for_drain();
   endtask

   // Mixed traffic over a small value pool, so that duplicates, hits and a full heap recur.
   task automatic test_random_mix();
      value_type             pool [POOL_SIZE];
      value_type             v;
      logic [OP_WIDTH-1:0]   op;
      int                    pick;
      pool[0] = VALUE_MIN;
      pool[1] = VALUE_MAX;
      pool[2] = '0;
      for (int i = 3; i < POOL_SIZE; i++) pool[i] = $urandom;
      for (int n = 0; n < 310; n++) begin
         // Switch between idling and back-to-back stretches on both sides.
         if (n % 60 == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         if (n % 100 == 99) wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = OP_INSERT;
         else if (pick < 65) op = OP_REMOVE;
         else if (pick < 85) op = OP_SEARCH;
         else if (pick < 92) op = OP_READOUT;
         else if (pick < 95) op = OP_CLEAR;
         else                op = $urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI);
         if ($urandom_range(0, 3) == 0) v = $urandom;
         else                           v = pool[$urandom_range(0, POOL_SIZE - 1)];
         // Aim removes and searches at stored values half of the time.
         if ((op == OP_REMOVE || op == OP_SEARCH) && heap_size > 0 && $urandom_range(0, 1))
            v = heap_vals[$urandom_range(0, heap_size - 1)];
         send_item(op, v);
      end
   endtask

   // Response side: random stall after each accepted transaction.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) rsp_stall = draw_wait(rsp_quiet);
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compares each response transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("Response transaction with nothing outstanding");
            error_count++;
         end else begin
            front_reply = pending_replies.pop_front();
            check_field("ok", front_reply.ok, rsp_bus.ok);
            check_field("full_refused", front_reply.full_refused, rsp_bus.full_refused);
            check_field("out_value", front_reply.out_value, rsp_bus.out_value);
            check_field("has_value", front_reply.has_value, rsp_bus.has_value);
            check_field("last", front_reply.last, rsp_bus.last);
            check_field("entry_count", front_reply.entry_count, rsp_bus.entry_count);
            check_field("empty_res", front_reply.empty_res, rsp_bus.empty_res);
         end
      end
   end

   // Guard against a hung core.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_INSERT;
      req_bus.item_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_full_heap();
      test_random_mix();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ max_heap_priority_queue_core.f @@
src/mhpq_pkg.sv
src/mhpq_req_if.sv
src/mhpq_rsp_if.sv
src/mhpq_cell.sv
src/mhpq_chain.sv
src/max_heap_priority_queue_core.sv
test/max_heap_priority_queue_core_tb.sv
